>>> hdl/tmff_pkg.sv
// ----------------------------------------------------------------------------
// tmff_pkg
// Shared constants for the temporal max frame filter: pixel width, default
// sizes, reset values of the registers, operation and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tmff_pkg;

  localparam int PIX_W           = 8;
  localparam int FRAME_SLOTS_DEF = 16;
  localparam int MAX_BYTES_DEF   = 1048576;

  localparam int FRAMES_W = 5;
  localparam int BYTES_W  = 21;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  localparam logic [FRAMES_W-1:0] RESET_FRAMES      = 5'd15;
  localparam logic [BYTES_W-1:0]  RESET_FRAME_BYTES = 21'd460800;

  // in_tuser codes
  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // register select, taken from the word address bit of paddr
  localparam logic REG_FRAMES = 1'b0;
  localparam logic REG_BYTES  = 1'b1;

endpackage

`default_nettype wire

>>> hdl/tmff_store.sv
// ----------------------------------------------------------------------------
// tmff_store
// Frame ring memory: one row per position, one byte lane per slot. A read
// returns the whole row in the next cycle; the write-back stores that row with
// the current slot's lane replaced by the new byte.
// ----------------------------------------------------------------------------
`default_nettype none

module tmff_store #(
  parameter int SLOTS = 16,
  parameter int DEPTH = 1048576
) (
  input  wire                                   clk,
  input  wire                                   rd_en,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  input  wire                                   wb_en,
  input  wire  [$clog2(SLOTS)-1:0]              wb_lane,
  input  wire  [tmff_pkg::PIX_W-1:0]            wb_byte,
  output logic [SLOTS*tmff_pkg::PIX_W-1:0]      rd_row
);
  import tmff_pkg::*;

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ROW_W = SLOTS * PIX_W;

  logic [ROW_W-1:0] row_mem [DEPTH];
  logic [ROW_W-1:0] rd_row_r;
  logic [AW-1:0]    addr_r;
  logic [ROW_W-1:0] wb_row;

  always_comb begin
    wb_row = rd_row_r;
    wb_row[int'(wb_lane)*PIX_W +: PIX_W] = wb_byte;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row_r <= row_mem[rd_addr];
      addr_r   <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_en) begin
      row_mem[addr_r] <= wb_row;
    end
  end

  assign rd_row = rd_row_r;

endmodule

`default_nettype wire

>>> hdl/tmff_reduce.sv
// ----------------------------------------------------------------------------
// tmff_reduce
// Masked maximum over the byte lanes of one row. Groups of four lanes are
// reduced and registered, then the group maxima and the new byte are merged.
// ----------------------------------------------------------------------------
`default_nettype none

module tmff_reduce #(
  parameter int SLOTS = 16
) (
  input  wire                              clk,
  input  wire                              en,
  input  wire  [SLOTS*tmff_pkg::PIX_W-1:0] row,
  input  wire  [SLOTS-1:0]                 mask,
  input  wire  [tmff_pkg::PIX_W-1:0]       new_byte,
  output logic [tmff_pkg::PIX_W-1:0]       best
);
  import tmff_pkg::*;

  localparam int NGRP  = (SLOTS + 3) / 4;
  localparam int LANES = NGRP * 4;

  logic [LANES*PIX_W-1:0] row_pad;
  logic [LANES-1:0]       mask_pad;
  logic [PIX_W-1:0]       grp_nxt [NGRP];
  logic [PIX_W-1:0]       grp_r   [NGRP];

  assign row_pad  = {{((LANES - SLOTS)*PIX_W){1'b0}}, row};
  assign mask_pad = {{(LANES - SLOTS){1'b0}}, mask};

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < 4; k++) begin
        if (mask_pad[g*4+k] && (row_pad[(g*4+k)*PIX_W +: PIX_W] > grp_nxt[g])) begin
          grp_nxt[g] = row_pad[(g*4+k)*PIX_W +: PIX_W];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < NGRP; g++) begin
        grp_r[g] <= grp_nxt[g];
      end
    end
  end

  always_comb begin
    best = new_byte;
    for (int g = 0; g < NGRP; g++) begin
      if (grp_r[g] > best) begin
        best = grp_r[g];
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/temporal_max_frame_filter.sv
// ----------------------------------------------------------------------------
// temporal_max_frame_filter
// Per-position maximum of a component stream over a ring of stored frames.
//
// in_*  : stream of components; in_tuser selects push or clear, in_tdata
//         carries the byte. A push gives one result, a clear gives none.
// out_* : out_tdata is the maximum of the new byte and the valid slots in
//         use but the written one; out_tlast marks a frame's final component.
// cfg_* : APB port, frames_in_use at 0x0, frame_bytes at 0x4. Any write
//         empties the history. Write only while the stream is idle.
// A push runs through these steps: accept and issue the row read, reduce
// the row and write it back, merge and load the output register. The
// sequencer holds in_tready low from the accepting edge until the result
// is loaded into the output register, so no new item is taken before
// then; a clear keeps the sequencer idle, with in_tready high.
// A stalled receiver holds the result in the output register and the
// block waits in the merge step until the register is free.
// Reset (synchronous, rst_n low) empties the history and restores the
// register defaults; the frame memory itself is not cleared, slots are
// tracked by a valid mask.
// ----------------------------------------------------------------------------
`default_nettype none

module temporal_max_frame_filter #(
  parameter int FRAME_SLOTS     = tmff_pkg::FRAME_SLOTS_DEF,
  parameter int MAX_FRAME_BYTES = tmff_pkg::MAX_BYTES_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  // input stream
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire  [7:0]                   in_tdata,     // [7:0] value
  input  wire                          in_tuser,     // [0] operation
  // result stream
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [7:0]                   out_tdata,    // [7:0] max_value
  output logic                         out_tlast,    // last_of_frame
  // configuration
  input  wire                          cfg_psel,
  input  wire                          cfg_penable,
  input  wire                          cfg_pwrite,
  input  wire  [tmff_pkg::CFG_AW-1:0]  cfg_paddr,
  input  wire  [tmff_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [tmff_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready
);
  import tmff_pkg::*;

  localparam int AW   = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;
  localparam int LW   = $clog2(FRAME_SLOTS);
  localparam int BC_W = ($clog2(MAX_FRAME_BYTES + 1) > BYTES_W) ?
                        $clog2(MAX_FRAME_BYTES + 1) : BYTES_W;
  localparam int SC_W = ($clog2(FRAME_SLOTS + 1) > FRAMES_W) ?
                        $clog2(FRAME_SLOTS + 1) : FRAMES_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_RED  = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic [FRAMES_W-1:0]    frames_r;
  logic [BYTES_W-1:0]     bytes_r;
  logic [AW-1:0]          pos_r, pos_nxt;
  logic [LW-1:0]          ws_r, ws_nxt;
  logic [FRAME_SLOTS-1:0] valid_r, valid_nxt;
  logic [FRAME_SLOTS-1:0] mask_r, mask_nxt;
  logic [PIX_W-1:0]       value_r;
  logic [LW-1:0]          lane_r;
  logic                   last_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]       out_data_r;
  logic                   out_last_r;

  logic                   accept, push, clr, cfg_wr, out_load;
  logic [SC_W-1:0]        slots_used;
  logic [BC_W-1:0]        bytes_used;
  logic [BC_W-1:0]        pos_ext;
  logic [SC_W-1:0]        ws_ext;
  logic [AW-1:0]          pos_eff;
  logic [LW-1:0]          ws_eff;
  logic                   last_nxt;
  logic [FRAME_SLOTS*PIX_W-1:0] row;
  logic [PIX_W-1:0]       best;

  // ---------------- configuration ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_BYTES) ?
                      {{(CFG_DW-BYTES_W){1'b0}}, bytes_r} :
                      {{(CFG_DW-FRAMES_W){1'b0}}, frames_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_r <= RESET_FRAMES;
      bytes_r  <= RESET_FRAME_BYTES;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_FRAMES) begin
        frames_r <= cfg_pwdata[FRAMES_W-1:0];
      end else begin
        bytes_r <= cfg_pwdata[BYTES_W-1:0];
      end
    end
  end

  // clamp the registers to the supported range
  always_comb begin
    slots_used = {{(SC_W-FRAMES_W){1'b0}}, frames_r};
    if (frames_r == '0) begin
      slots_used = SC_W'(1);
    end else if (slots_used > SC_W'(FRAME_SLOTS)) begin
      slots_used = SC_W'(FRAME_SLOTS);
    end
    bytes_used = {{(BC_W-BYTES_W){1'b0}}, bytes_r};
    if (bytes_r == '0) begin
      bytes_used = BC_W'(1);
    end else if (bytes_used > BC_W'(MAX_FRAME_BYTES)) begin
      bytes_used = BC_W'(MAX_FRAME_BYTES);
    end
  end

  // ---------------- ring position ----------------
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid & in_tready;
  assign push      = accept & (in_tuser == OP_PUSH);
  assign clr       = accept & (in_tuser == OP_CLEAR);

  assign pos_eff  = ({{(BC_W-AW){1'b0}}, pos_r} >= bytes_used) ? '0 : pos_r;
  assign ws_eff   = ({{(SC_W-LW){1'b0}}, ws_r} >= slots_used) ? '0 : ws_r;
  assign pos_ext  = {{(BC_W-AW){1'b0}}, pos_eff};
  assign ws_ext   = {{(SC_W-LW){1'b0}}, ws_eff};
  assign last_nxt = (pos_ext + BC_W'(1)) >= bytes_used;

  always_comb begin
    for (int s = 0; s < FRAME_SLOTS; s++) begin
      mask_nxt[s] = valid_r[s] && (SC_W'(s) < slots_used) && (LW'(s) != ws_eff);
    end
  end

  always_comb begin
    pos_nxt   = pos_r;
    ws_nxt    = ws_r;
    valid_nxt = valid_r;
    if (cfg_wr || clr) begin
      pos_nxt   = '0;
      ws_nxt    = '0;
      valid_nxt = '0;
    end else if (push) begin
      if (last_nxt) begin
        valid_nxt = valid_r | (FRAME_SLOTS'(1) << ws_eff);
        pos_nxt   = '0;
        ws_nxt    = ((ws_ext + SC_W'(1)) >= slots_used) ? '0 : (ws_eff + LW'(1));
      end else begin
        pos_nxt = pos_eff + AW'(1);
      end
    end
  end

  // ---------------- sequencer ----------------
  assign out_load = (state_r == S_RED) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (push) begin
          state_nxt = S_RD;
        end
      end
      S_RD: state_nxt = S_RED;
      S_RED: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      ws_r        <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      ws_r        <= ws_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      value_r <= in_tdata;
      lane_r  <= ws_eff;
      last_r  <= last_nxt;
      mask_r  <= mask_nxt;
    end
    if (out_load) begin
      out_data_r <= best;
      out_last_r <= last_r;
    end
  end

  tmff_store #(
    .SLOTS (FRAME_SLOTS),
    .DEPTH (MAX_FRAME_BYTES)
  ) u_store (
    .clk     (clk),
    .rd_en   (push),
    .rd_addr (pos_eff),
    .wb_en   (state_r == S_RD),
    .wb_lane (lane_r),
    .wb_byte (value_r),
    .rd_row  (row)
  );

  tmff_reduce #(
    .SLOTS (FRAME_SLOTS)
  ) u_reduce (
    .clk      (clk),
    .en       (state_r == S_RD),
    .row      (row),
    .mask     (mask_r),
    .new_byte (value_r),
    .best     (best)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // ---------------- assertions ----------------
  a_push_reads: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (state_r == S_RD))
    else $error("push transfer did not start a row read");

  a_rd_after_push: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> $past(in_tvalid && in_tready && (in_tuser == OP_PUSH)))
    else $error("row read without a push transfer");

  a_own_lane_masked: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> !mask_r[lane_r])
    else $error("current write slot included in the maximum");

  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> (valid_r == '0) && (pos_r == '0) && (ws_r == '0))
    else $error("register write did not empty the history");

endmodule

`default_nettype wire
